// File: hdl/dbc_pkg.sv
// Shared types, constants and helpers for the delimiter balance checker.
// No dependencies; imported by every module of the block.
package dbc_pkg;

    // Window and depth sizing
    localparam int MAX_TAG_BYTES = 8;
    localparam int DEPTH_BITS    = 16;
    localparam int FILL_W        = $clog2(MAX_TAG_BYTES + 1);
    localparam int IDX_W         = (MAX_TAG_BYTES > 1) ? $clog2(MAX_TAG_BYTES) : 1;
    localparam int LEN_W         = 4;
    localparam int SKIP_W        = IDX_W;
    localparam int TAG_W         = 8 * MAX_TAG_BYTES;
    localparam int CFG_W         = 64;
    localparam int CFG_IDX_W     = 2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_OPEN_TAG  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OPEN_LEN  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CLOSE_TAG = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CLOSE_LEN = 2'd3;

    typedef logic [7:0]            t_byte;
    typedef logic [DEPTH_BITS-1:0] t_depth;

    // Window status handed from the cell row to the decision unit
    typedef struct packed {
        logic decidable;   // head position can be decided now
        logic head_last;   // head byte ends its stream
        logic open_hit;    // opening tag sits at the head
        logic close_hit;   // closing tag sits at the head
    } t_win_stat;

    // Clamp a configured tag length into 1..MAX_TAG_BYTES
    function automatic logic [LEN_W-1:0] eff_len(input logic [LEN_W-1:0] len);
        logic [LEN_W-1:0] res;
        res = len;
        if (len == '0) begin
            res = LEN_W'(1);
        end else if (len > LEN_W'(MAX_TAG_BYTES)) begin
            res = LEN_W'(MAX_TAG_BYTES);
        end
        return res;
    endfunction

endpackage

// File: hdl/dbc_cell.sv
// One byte slot of the lookahead window: holds a byte and its end mark,
// shifts toward the head and compares itself against both tags. Uses dbc_pkg.
module dbc_cell
    import dbc_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_shift,       // head dropped: take the neighbor's contents
    input  logic  i_load,        // new transfer lands in this slot
    input  t_byte i_load_byte,
    input  logic  i_load_last,
    input  t_byte i_next_byte,   // neighbor toward the tail
    input  logic  i_next_last,
    input  t_byte i_open_byte,   // tag bytes for this slot
    input  t_byte i_close_byte,
    input  logic  i_in_fill,     // slot lies below the fill count
    input  logic  i_prev_ok,     // every slot nearer the head is present and not last
    output t_byte o_byte,
    output logic  o_last,
    output logic  o_present,
    output logic  o_pass_ok,
    output logic  o_open_eq,
    output logic  o_close_eq
);

    t_byte r_byte;
    logic  r_last;
    t_byte n_byte;
    logic  n_last;

    // Load beats shift; otherwise hold
    always_comb begin
        n_byte = r_byte;
        n_last = r_last;
        if (i_load) begin
            n_byte = i_load_byte;
            n_last = i_load_last;
        end else if (i_shift) begin
            n_byte = i_next_byte;
            n_last = i_next_last;
        end
    end

    always_ff @(posedge i_clk) begin
        r_byte <= n_byte;
        r_last <= n_last;
    end

    // A slot counts only up to and including the first end mark
    assign o_present  = i_in_fill && i_prev_ok;
    assign o_pass_ok  = o_present && !r_last;
    assign o_open_eq  = o_present && (r_byte == i_open_byte);
    assign o_close_eq = o_present && (r_byte == i_close_byte);
    assign o_byte     = r_byte;
    assign o_last     = r_last;

endmodule

// File: hdl/dbc_decide.sv
// Head decision unit: skip count, nesting depth, failure and overflow flags,
// and the verdict output register. Uses dbc_pkg.
module dbc_decide
    import dbc_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_win_stat        i_stat,
    input  logic [LEN_W-1:0] i_olen,
    input  logic [LEN_W-1:0] i_clen,
    input  logic             i_m_tready,
    output logic             o_drop,
    output logic             o_m_tvalid,
    output logic             o_balanced,
    output logic             o_unmatched_close,
    output logic             o_depth_overflow
);

    localparam t_depth DEPTH_MAX = '1;

    logic              r_failed, n_failed;
    logic              r_ovf, n_ovf;
    logic [SKIP_W-1:0] r_skip, n_skip;
    t_depth            r_depth, n_depth;
    logic              r_valid, n_valid;
    logic              r_bal, r_unm, r_dov;
    logic              go;
    logic              drop;
    logic              emit;

    always_comb begin
        n_failed = r_failed;
        n_ovf    = r_ovf;
        n_skip   = r_skip;
        n_depth  = r_depth;
        drop     = 1'b0;
        // Hold a stream end while the previous verdict waits
        go = i_stat.decidable && !(i_stat.head_last && r_valid && !i_m_tready);
        if (go) begin
            if (r_failed) begin
                drop = 1'b1;
            end else if (r_skip != '0) begin
                n_skip = r_skip - SKIP_W'(1);
                drop   = 1'b1;
            end else if (i_stat.open_hit) begin
                if (r_depth == DEPTH_MAX) begin
                    n_ovf = 1'b1;
                end else begin
                    n_depth = r_depth + t_depth'(1);
                end
                n_skip = SKIP_W'(i_olen - LEN_W'(1));
                drop   = 1'b1;
            end else if (i_stat.close_hit) begin
                if (r_depth == '0) begin
                    n_failed = 1'b1;
                end else begin
                    n_depth = r_depth - t_depth'(1);
                    n_skip  = SKIP_W'(i_clen - LEN_W'(1));
                    drop    = 1'b1;
                end
            end else begin
                drop = 1'b1;
            end
        end
        emit    = drop && i_stat.head_last;
        n_valid = emit || (r_valid && !i_m_tready);
    end

    // Advance stream state; clear it once the verdict is taken into the output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_failed <= 1'b0;
            r_ovf    <= 1'b0;
            r_skip   <= '0;
            r_depth  <= '0;
            r_valid  <= 1'b0;
        end else begin
            r_valid <= n_valid;
            if (emit) begin
                r_failed <= 1'b0;
                r_ovf    <= 1'b0;
                r_skip   <= '0;
                r_depth  <= '0;
            end else begin
                r_failed <= n_failed;
                r_ovf    <= n_ovf;
                r_skip   <= n_skip;
                r_depth  <= n_depth;
            end
        end
    end

    // Verdict payload
    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_bal <= !n_failed && !n_ovf && (n_depth == '0);
            r_unm <= n_failed;
            r_dov <= n_ovf;
        end
    end

    assign o_drop            = drop;
    assign o_m_tvalid        = r_valid;
    assign o_balanced        = r_bal;
    assign o_unmatched_close = r_unm;
    assign o_depth_overflow  = r_dov;

endmodule

// File: hdl/delimiter_balance_checker_top.sv
// Top level of the delimiter balance checker: configuration registers,
// the row of window cells and the decision unit. Uses dbc_pkg, dbc_cell, dbc_decide.

// The block takes one text byte per cycle on s_axis while s_axis_tready is high,
// and gives one three-bit verdict on m_axis per stream, after the byte marked by
// tlast. Bytes shift through a row of eight window cells; the head position is
// decided once eight bytes stand in the window or the stream's last byte has
// arrived, one position per cycle in the decision unit unless the head is held.
// The verdict is registered as the last byte leaves the head, after every
// undecided position still in the window and any stall of a previous verdict on
// m_axis; a closing tag at depth zero fails the stream and holds the head for
// one more decision. Bytes of the next stream are taken meanwhile while the
// window has room. s_axis_tready falls only when the window is full and the head
// cannot move: a verdict stalled on m_axis, or the cycle a closing tag is met at
// depth zero. The user writes configuration only between streams; not enforced.
module delimiter_balance_checker_top
    import dbc_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // configuration write port
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_wdata,
    // text stream
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [7:0]           s_axis_tdata,   // [7:0] text_byte
    input  logic                 s_axis_tlast,   // final_byte
    // verdict stream
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [7:0]           m_axis_tdata    // [0] balanced, [1] unmatched_close,
                                                 // [2] depth_overflow, [7:3] zero
);

    logic [TAG_W-1:0]  r_open_tag;
    logic [TAG_W-1:0]  r_close_tag;
    logic [LEN_W-1:0]  r_open_len;
    logic [LEN_W-1:0]  r_close_len;
    logic [FILL_W-1:0] r_fill, n_fill;

    logic [LEN_W-1:0]  olen, clen;
    logic              acc;
    logic              drop;
    logic [IDX_W-1:0]  widx;
    t_win_stat         stat;

    t_byte             cell_byte [MAX_TAG_BYTES];
    logic [MAX_TAG_BYTES-1:0] cell_last;
    logic [MAX_TAG_BYTES-1:0] cell_present;
    logic [MAX_TAG_BYTES-1:0] cell_pass;
    logic [MAX_TAG_BYTES-1:0] cell_open_eq;
    logic [MAX_TAG_BYTES-1:0] cell_close_eq;
    logic [MAX_TAG_BYTES-1:0] open_ok;
    logic [MAX_TAG_BYTES-1:0] close_ok;

    logic bal, unm, dov;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open_tag  <= '0;
            r_close_tag <= '0;
            r_open_len  <= LEN_W'(1);
            r_close_len <= LEN_W'(1);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_OPEN_TAG:  r_open_tag  <= i_cfg_wdata[TAG_W-1:0];
                CFG_OPEN_LEN:  r_open_len  <= i_cfg_wdata[LEN_W-1:0];
                CFG_CLOSE_TAG: r_close_tag <= i_cfg_wdata[TAG_W-1:0];
                CFG_CLOSE_LEN: r_close_len <= i_cfg_wdata[LEN_W-1:0];
                default: ;
            endcase
        end
    end

    assign olen = eff_len(r_open_len);
    assign clen = eff_len(r_close_len);

    // Take a transfer while a slot is free or the head leaves this cycle
    assign s_axis_tready = (r_fill != FILL_W'(MAX_TAG_BYTES)) || drop;
    assign acc           = s_axis_tvalid && s_axis_tready;
    assign widx          = drop ? (r_fill[IDX_W-1:0] - IDX_W'(1)) : r_fill[IDX_W-1:0];
    assign n_fill        = r_fill + FILL_W'(acc) - FILL_W'(drop);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else begin
            r_fill <= n_fill;
        end
    end

    // Row of window cells, head at index 0
    for (genvar k = 0; k < MAX_TAG_BYTES; k++) begin : g_cell
        t_byte next_byte;
        logic  next_last;
        logic  prev_ok;

        if (k == MAX_TAG_BYTES - 1) begin : g_tail
            assign next_byte = s_axis_tdata;
            assign next_last = s_axis_tlast;
        end else begin : g_mid
            assign next_byte = cell_byte[k+1];
            assign next_last = cell_last[k+1];
        end

        if (k == 0) begin : g_head
            assign prev_ok = 1'b1;
        end else begin : g_rest
            assign prev_ok = cell_pass[k-1];
        end

        dbc_cell u_cell (
            .i_clk        (i_clk),
            .i_shift      (drop),
            .i_load       (acc && (widx == IDX_W'(k))),
            .i_load_byte  (s_axis_tdata),
            .i_load_last  (s_axis_tlast),
            .i_next_byte  (next_byte),
            .i_next_last  (next_last),
            .i_open_byte  (r_open_tag[8*k +: 8]),
            .i_close_byte (r_close_tag[8*k +: 8]),
            .i_in_fill    (r_fill > FILL_W'(k)),
            .i_prev_ok    (prev_ok),
            .o_byte       (cell_byte[k]),
            .o_last       (cell_last[k]),
            .o_present    (cell_present[k]),
            .o_pass_ok    (cell_pass[k]),
            .o_open_eq    (cell_open_eq[k]),
            .o_close_eq   (cell_close_eq[k])
        );

        // Slots past the tag length do not take part in the match
        assign open_ok[k]  = (LEN_W'(k) >= olen) || cell_open_eq[k];
        assign close_ok[k] = (LEN_W'(k) >= clen) || cell_close_eq[k];
    end

    // Window status for the head position
    assign stat.decidable = (r_fill == FILL_W'(MAX_TAG_BYTES)) || |(cell_present & cell_last);
    assign stat.head_last = cell_last[0];
    assign stat.open_hit  = &open_ok;
    assign stat.close_hit = &close_ok;

    dbc_decide u_decide (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_stat            (stat),
        .i_olen            (olen),
        .i_clen            (clen),
        .i_m_tready        (m_axis_tready),
        .o_drop            (drop),
        .o_m_tvalid        (m_axis_tvalid),
        .o_balanced        (bal),
        .o_unmatched_close (unm),
        .o_depth_overflow  (dov)
    );

    assign m_axis_tdata = {5'b0, dov, unm, bal};

    // Checks
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FILL_W'(MAX_TAG_BYTES))
        else $error("window fill beyond capacity");

    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> (r_fill == FILL_W'(MAX_TAG_BYTES)))
        else $error("input stalled with free window slots");

    a_verdict_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(drop && cell_last[0]))
        else $error("verdict raised without a stream end leaving the head");

    a_verdict_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !(m_axis_tdata[0] && (m_axis_tdata[1] || m_axis_tdata[2])))
        else $error("balanced verdict together with a failure flag");

endmodule
